// ----- sv/ptlc_pkg.sv -----
// ----------------------------------------------------------------------------
// ptlc_pkg
// Shared types and constants for the pedestrian traffic light controller:
// configuration layout, register indexes, light phases.
// ----------------------------------------------------------------------------
`default_nettype none

package ptlc_pkg;

  localparam int CFG_TIME_W = 20;
  localparam int DUTY_W     = 10;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GREEN_TIME     = 3'd0,
    CFG_MIN_GREEN_TIME = 3'd1,
    CFG_YELLOW_TIME    = 3'd2,
    CFG_RED_TIME       = 3'd3,
    CFG_PRESS_COOLDOWN = 3'd4,
    CFG_LIT_DUTY       = 3'd5,
    CFG_DARK_DUTY      = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_GREEN  = 3'b001,
    PH_YELLOW = 3'b010,
    PH_RED    = 3'b100
  } phase_e;

  typedef struct packed {
    logic [CFG_TIME_W-1:0] green_time;
    logic [CFG_TIME_W-1:0] min_green_time;
    logic [CFG_TIME_W-1:0] yellow_time;
    logic [CFG_TIME_W-1:0] red_time;
    logic [CFG_TIME_W-1:0] press_cooldown;
    logic [DUTY_W-1:0]     lit_duty;
    logic [DUTY_W-1:0]     dark_duty;
  } cfg_t;

  typedef struct packed {
    phase_e phase;
    logic   request;
  } step_res_t;

  localparam logic [CFG_TIME_W-1:0] RST_GREEN_TIME     = 20'd30000;
  localparam logic [CFG_TIME_W-1:0] RST_MIN_GREEN_TIME = 20'd15000;
  localparam logic [CFG_TIME_W-1:0] RST_YELLOW_TIME    = 20'd4000;
  localparam logic [CFG_TIME_W-1:0] RST_RED_TIME       = 20'd26000;
  localparam logic [CFG_TIME_W-1:0] RST_PRESS_COOLDOWN = 20'd10000;
  localparam logic [DUTY_W-1:0]     RST_LIT_DUTY       = 10'd1023;
  localparam logic [DUTY_W-1:0]     RST_DARK_DUTY      = 10'd0;

endpackage

`default_nettype wire

// ----- sv/ptlc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ptlc_cfg_regs
// Configuration register bank written through a plain indexed write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ptlc_cfg_regs
  import ptlc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.green_time     <= RST_GREEN_TIME;
      cfg_q.min_green_time <= RST_MIN_GREEN_TIME;
      cfg_q.yellow_time    <= RST_YELLOW_TIME;
      cfg_q.red_time       <= RST_RED_TIME;
      cfg_q.press_cooldown <= RST_PRESS_COOLDOWN;
      cfg_q.lit_duty       <= RST_LIT_DUTY;
      cfg_q.dark_duty      <= RST_DARK_DUTY;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GREEN_TIME:     cfg_q.green_time     <= cfg_data_i[CFG_TIME_W-1:0];
        CFG_MIN_GREEN_TIME: cfg_q.min_green_time <= cfg_data_i[CFG_TIME_W-1:0];
        CFG_YELLOW_TIME:    cfg_q.yellow_time    <= cfg_data_i[CFG_TIME_W-1:0];
        CFG_RED_TIME:       cfg_q.red_time       <= cfg_data_i[CFG_TIME_W-1:0];
        CFG_PRESS_COOLDOWN: cfg_q.press_cooldown <= cfg_data_i[CFG_TIME_W-1:0];
        CFG_LIT_DUTY:       cfg_q.lit_duty       <= cfg_data_i[DUTY_W-1:0];
        CFG_DARK_DUTY:      cfg_q.dark_duty      <= cfg_data_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- sv/ptlc_step.sv -----
// ----------------------------------------------------------------------------
// ptlc_step
// Per-tick controller state and its combinational update: elapsed counters,
// phase sequencing, button edge detection and crossing request.
// ----------------------------------------------------------------------------
`default_nettype none

module ptlc_step
  import ptlc_pkg::*;
#(
  parameter int TIME_BITS = 20
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  wire logic button_level_i,
  input  wire cfg_t cfg_i,
  output step_res_t res_o
);

  localparam int CW = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;

  phase_e               phase_q, phase_d;
  logic [TIME_BITS-1:0] phase_el_q, phase_el_d;
  logic [TIME_BITS-1:0] press_el_q, press_el_d;
  logic                 pressed_q, pressed_d;
  logic                 last_lvl_q;
  logic                 req_q, req_d;

  logic [TIME_BITS-1:0] phase_inc, press_inc;
  logic [CW-1:0]        phase_cmp, press_cmp;
  logic                 press_edge, cool_ok;

  always_comb begin
    phase_inc  = (phase_el_q == '1) ? phase_el_q : phase_el_q + TIME_BITS'(1);
    press_inc  = (press_el_q == '1) ? press_el_q : press_el_q + TIME_BITS'(1);
    phase_cmp  = CW'(phase_inc);
    press_cmp  = CW'(press_inc);
    phase_d    = phase_q;
    phase_el_d = phase_inc;
    press_el_d = press_inc;
    pressed_d  = pressed_q;
    req_d      = req_q;

    // phase step
    case (phase_q)
      PH_GREEN: begin
        if (phase_cmp >= CW'(cfg_i.green_time) ||
            (req_q && phase_cmp >= CW'(cfg_i.min_green_time))) begin
          phase_d    = PH_YELLOW;
          phase_el_d = '0;
          req_d      = 1'b0;
        end
      end
      PH_YELLOW: begin
        if (phase_cmp >= CW'(cfg_i.yellow_time)) begin
          phase_d    = PH_RED;
          phase_el_d = '0;
        end
      end
      PH_RED: begin
        if (phase_cmp >= CW'(cfg_i.red_time)) begin
          phase_d    = PH_GREEN;
          phase_el_d = '0;
        end
      end
      default: ;
    endcase

    // button
    press_edge = last_lvl_q && !button_level_i;
    cool_ok    = !pressed_q || (press_cmp >= CW'(cfg_i.press_cooldown));
    if (press_edge && phase_d == PH_GREEN && cool_ok) begin
      req_d      = 1'b1;
      press_el_d = '0;
      pressed_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_GREEN;
      phase_el_q <= '0;
      press_el_q <= '0;
      pressed_q  <= 1'b0;
      last_lvl_q <= 1'b1;
      req_q      <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      phase_el_q <= phase_el_d;
      press_el_q <= press_el_d;
      pressed_q  <= pressed_d;
      last_lvl_q <= button_level_i;
      req_q      <= req_d;
    end
  end

  assign res_o.phase   = phase_d;
  assign res_o.request = req_d;

  // request only raised while green
  a_req_in_green: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(req_q) |-> phase_q == PH_GREEN)
    else $error("request set outside green");

  // phase change restarts the phase timer
  a_phase_el_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_d != phase_q |=> phase_el_q == '0)
    else $error("phase timer not cleared on phase change");

  // ending green serves the request
  a_green_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_GREEN && phase_d == PH_YELLOW |=> !req_q)
    else $error("request survived end of green");

  // no tick, no state change
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(phase_el_q) && $stable(req_q))
    else $error("state moved without a tick");

endmodule

`default_nettype wire

// ----- sv/pedestrian_traffic_light_controller_core.sv -----
// ----------------------------------------------------------------------------
// pedestrian_traffic_light_controller_core
// Traffic light sequencer with pedestrian crossing request.
//
// Input channel (in_valid_i/in_ready_o): one beat per millisecond tick,
// carrying the sampled button level (0 = pressed).
// Output channel (out_valid_o/out_ready_i): one beat per input beat, with
// the red, yellow and green lamp duties and the request flag.
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i; write
// only while no beats are in flight.
// Path: a beat accepted into the input register is processed by the
// state update into the output register and can be taken from there.
// Throughput: one beat per cycle while out_ready_i stays high, set by the
// combinational state update between the input and output registers.
// Reset: light green, timers zero, no request, config at defaults.
// Stall: when the receiver holds out_ready_i low, the output beat holds,
// one more beat may wait in the input register, then in_ready_o drops.
// ----------------------------------------------------------------------------
`default_nettype none

module pedestrian_traffic_light_controller_core
  import ptlc_pkg::*;
#(
  parameter int TIME_BITS = 20
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  button_level_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [DUTY_W-1:0]          red_duty_o,
  output logic [DUTY_W-1:0]          yellow_duty_o,
  output logic [DUTY_W-1:0]          green_duty_o,
  output logic                       request_pending_o
);

  cfg_t      cfg;
  step_res_t res;

  logic              s1_valid_q, s1_level_q;
  logic              out_valid_q;
  logic [DUTY_W-1:0] red_q, yellow_q, green_q;
  logic              req_q;
  logic              advance, step;

  ptlc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ptlc_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .button_level_i (s1_level_q),
    .cfg_i          (cfg),
    .res_o          (res)
  );

  assign advance    = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_level_q <= button_level_i;
    end
    if (step) begin
      red_q    <= (res.phase == PH_RED)    ? cfg.lit_duty : cfg.dark_duty;
      yellow_q <= (res.phase == PH_YELLOW) ? cfg.lit_duty : cfg.dark_duty;
      green_q  <= (res.phase == PH_GREEN)  ? cfg.lit_duty : cfg.dark_duty;
      req_q    <= res.request;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign red_duty_o        = red_q;
  assign yellow_duty_o     = yellow_q;
  assign green_duty_o      = green_q;
  assign request_pending_o = req_q;

endmodule

`default_nettype wire
